### hdl/smg_pkg.sv
// ---------------------------------------------------------------------------
// Stepper microstep generator package
// Shared widths, register indexes, configuration type and the sine table.
// ---------------------------------------------------------------------------
package smg_pkg;

    // Sine table geometry
    localparam int LUT_ENTRIES = 256;
    localparam int QUARTER     = LUT_ENTRIES / 4;
    localparam int LUT_AW      = $clog2(LUT_ENTRIES);
    localparam int QTR_AW      = $clog2(QUARTER);

    // Field widths
    localparam int SPEED_W = 14;
    localparam int PHASE_W = 16;
    localparam int AMP_W   = 8;
    localparam int CFG_DW  = 16;
    localparam int CFG_AW  = 3;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_SPEED_LIMIT = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ACCEL_STEP  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_AMP_MIN     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_AMP_MAX     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_KNEE_SPEED  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_AMP_SLOPE   = 3'd5;
    localparam logic [CFG_AW-1:0] REG_RATE_GAIN   = 3'd6;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [12:0] speed_limit;
        logic [8:0]  accel_step;
        logic [7:0]  amp_min;
        logic [7:0]  amp_max;
        logic [12:0] knee_speed;
        logic [15:0] amp_slope;
        logic [11:0] rate_gain;
    } t_cfg;

    // First quarter of a sine wave of amplitude 127, including the peak.
    localparam logic [6:0] QUARTER_SINE [0:QUARTER] = '{
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
        7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
        7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
        7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
        7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
        7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
        7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
        7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
        7'd127
    };

    // Full-wave signed sine built from the quarter table by symmetry.
    function automatic logic signed [7:0] sine_lut(input logic [LUT_AW-1:0] idx);
        logic [1:0]        quad;
        logic [QTR_AW-1:0] rem;
        logic [QTR_AW:0]   tidx;
        logic signed [7:0] mag;
        quad = idx[LUT_AW-1 -: 2];
        rem  = idx[QTR_AW-1:0];
        if (quad[0] == 1'b0) begin
            tidx = {1'b0, rem};
        end else begin
            tidx = (QTR_AW+1)'(QUARTER) - {1'b0, rem};
        end
        mag = $signed({1'b0, QUARTER_SINE[tidx]});
        return quad[1] ? -mag : mag;
    endfunction

endpackage

### hdl/smg_cfg.sv
// ---------------------------------------------------------------------------
// Stepper microstep generator configuration registers
// Write-only register file; writes to unused indexes are dropped.
// ---------------------------------------------------------------------------
module smg_cfg
    import smg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    // Register writes, each keeping only its field's low bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit <= 13'd4320;
            r_cfg.accel_step  <= 9'd80;
            r_cfg.amp_min     <= 8'd90;
            r_cfg.amp_max     <= 8'd255;
            r_cfg.knee_speed  <= 13'd960;
            r_cfg.amp_slope   <= 16'd352;
            r_cfg.rate_gain   <= 12'd447;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SPEED_LIMIT: r_cfg.speed_limit <= i_cfg_data[12:0];
                REG_ACCEL_STEP:  r_cfg.accel_step  <= i_cfg_data[8:0];
                REG_AMP_MIN:     r_cfg.amp_min     <= i_cfg_data[7:0];
                REG_AMP_MAX:     r_cfg.amp_max     <= i_cfg_data[7:0];
                REG_KNEE_SPEED:  r_cfg.knee_speed  <= i_cfg_data[12:0];
                REG_AMP_SLOPE:   r_cfg.amp_slope   <= i_cfg_data[15:0];
                REG_RATE_GAIN:   r_cfg.rate_gain   <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/smg_mul.sv
// ---------------------------------------------------------------------------
// Stepper microstep generator shared multiplier
// Signed multiplier with a registered product, loaded when enabled.
// ---------------------------------------------------------------------------
module smg_mul
    import smg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // The product holds between loads so the sequencer can use it later.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

### hdl/stepper_microstep_generator_unit.sv
// ---------------------------------------------------------------------------
// Stepper microstep generator
// Sine/cosine coil duty generator with a linear speed ramp.
// ---------------------------------------------------------------------------
// Usage: one input item per PWM period carries a signed target speed and a
// ramp-tick flag. Each item gives exactly one result item: two coil duties,
// the ramped speed and a halted flag.
// The input channel is i_in_valid / o_in_stall, the output channel is
// o_out_valid / i_out_stall. The block takes one item at a time; o_in_stall
// is high from acceptance until the sequencer returns to idle.
// Steps: an item with the ramp tick set passes ten sequencer steps
// (clamp, ramp, magnitude, two multiplier passes for step and amplitude,
// the amplitude step, phase, two multiplier passes for the duties and
// finish); an item without the tick passes only phase, the duty passes
// and finish. The sequencer steps all products through the single shared
// multiplier and takes no new item until the last one is finished.
// The output register holds a result while the receiver stalls; the next
// item is already accepted and worked on, and waits in its finish step
// until the output register is free.
// Reset (synchronous, active low) clears phase, speed, step and amplitude,
// loads the configuration defaults and empties the output register.
// ---------------------------------------------------------------------------
module stepper_microstep_generator_unit
    import smg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_AW-1:0]         i_cfg_idx,
    input  logic [CFG_DW-1:0]         i_cfg_data,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [SPEED_W-1:0] i_target_speed,
    input  logic                      i_ramp_tick,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_duty_a,
    output logic [7:0]                o_duty_b,
    output logic signed [SPEED_W-1:0] o_actual_speed,
    output logic                      o_halted
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_RAMP,
        S_MAG,
        S_STEP_MUL,
        S_AMP_MUL,
        S_AMP,
        S_PHASE,
        S_DUTY_A,
        S_DUTY_B,
        S_FINISH
    } t_state;

    t_cfg                      w_cfg;
    t_state                    r_state;
    logic signed [SPEED_W-1:0] r_target;
    logic signed [SPEED_W-1:0] r_speed;
    logic [SPEED_W-2:0]        r_mag;
    logic signed [SPEED_W-1:0] r_d;
    logic [PHASE_W-1:0]        r_step;
    logic [PHASE_W-1:0]        r_phase;
    logic [AMP_W-1:0]          r_amp;
    logic [7:0]                r_duty_a;
    logic                      r_out_valid;
    logic [7:0]                r_out_duty_a;
    logic [7:0]                r_out_duty_b;
    logic signed [SPEED_W-1:0] r_out_speed;
    logic                      r_out_halted;

    logic                      w_mul_en;
    logic signed [MUL_W-1:0]   w_mul_a;
    logic signed [MUL_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [SPEED_W:0]   w_lim;
    logic signed [SPEED_W:0]   w_tgt;
    logic signed [SPEED_W:0]   w_spd;
    logic signed [SPEED_W:0]   w_acc;
    logic signed [SPEED_W:0]   w_sum;
    logic signed [SPEED_W:0]   w_ramp;
    logic signed [SPEED_W:0]   w_clamp;
    logic [SPEED_W-1:0]        w_neg_speed;
    logic [12:0]               w_step_mag;
    logic [17:0]               w_amp_sum;
    logic [AMP_W-1:0]          w_amp;
    logic                      w_accept;
    logic                      w_out_free;

    smg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    smg_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Target clamp to the speed limit.
    always_comb begin
        w_lim = $signed({2'b00, w_cfg.speed_limit});
        w_tgt = $signed({r_target[SPEED_W-1], r_target});
        if (w_tgt > w_lim) begin
            w_clamp = w_lim;
        end else if (w_tgt < -w_lim) begin
            w_clamp = -w_lim;
        end else begin
            w_clamp = w_tgt;
        end
    end

    // Ramp the speed toward the clamped target by one acceleration step.
    always_comb begin
        w_spd = $signed({r_speed[SPEED_W-1], r_speed});
        w_acc = $signed({6'd0, w_cfg.accel_step});
        w_sum = w_spd;
        if (w_spd < w_tgt) begin
            w_sum  = w_spd + w_acc;
            w_ramp = (w_sum > w_tgt) ? w_tgt : w_sum;
        end else if (w_spd > w_tgt) begin
            w_sum  = w_spd - w_acc;
            w_ramp = (w_sum < w_tgt) ? w_tgt : w_sum;
        end else begin
            w_ramp = w_spd;
        end
    end

    assign w_neg_speed = -r_speed;

    // Phase step magnitude from the registered speed times gain product.
    always_comb begin
        if (|w_prod[PROD_W-1:28]) begin
            w_step_mag = 13'h1FFF;
        end else begin
            w_step_mag = w_prod[24:12];
        end
    end

    // Amplitude: minimum plus the slope term, capped at the maximum.
    always_comb begin
        w_amp_sum = {10'd0, w_cfg.amp_min} + {1'b0, w_prod[28:12]};
        if (r_d[SPEED_W-1] || (r_d == '0)) begin
            w_amp = w_cfg.amp_min;
        end else if (w_amp_sum > {10'd0, w_cfg.amp_max}) begin
            w_amp = w_cfg.amp_max;
        end else begin
            w_amp = w_amp_sum[AMP_W-1:0];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            S_STEP_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed({4'd0, r_mag});
                w_mul_b  = $signed({5'd0, w_cfg.rate_gain});
            end
            S_AMP_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed({4'd0, r_d[12:0]});
                w_mul_b  = $signed({1'b0, w_cfg.amp_slope});
            end
            S_DUTY_A: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_W'(sine_lut(r_phase[PHASE_W-1 -: LUT_AW]));
                w_mul_b  = $signed({9'd0, r_amp});
            end
            S_DUTY_B: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_W'(sine_lut(r_phase[PHASE_W-1 -: LUT_AW]
                                           + LUT_AW'(QUARTER)));
                w_mul_b  = $signed({9'd0, r_amp});
            end
            default: begin
            end
        endcase
    end

    // Sequencer with the datapath and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= '0;
            r_step      <= '0;
            r_phase     <= '0;
            r_amp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The finish step reloads the output register itself.
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_target <= i_target_speed;
                        r_state  <= i_ramp_tick ? S_CLAMP : S_PHASE;
                    end
                end
                S_CLAMP: begin
                    r_target <= w_clamp[SPEED_W-1:0];
                    r_state  <= S_RAMP;
                end
                S_RAMP: begin
                    r_speed <= w_ramp[SPEED_W-1:0];
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_mag   <= r_speed[SPEED_W-1] ? w_neg_speed[SPEED_W-2:0]
                                                  : r_speed[SPEED_W-2:0];
                    r_state <= S_STEP_MUL;
                end
                S_STEP_MUL: begin
                    r_d     <= $signed({1'b0, r_mag}) - $signed({1'b0, w_cfg.knee_speed});
                    r_state <= S_AMP_MUL;
                end
                S_AMP_MUL: begin
                    r_step  <= r_speed[SPEED_W-1] ? -{3'd0, w_step_mag}
                                                  : {3'd0, w_step_mag};
                    r_state <= S_AMP;
                end
                S_AMP: begin
                    r_amp   <= w_amp;
                    r_state <= S_PHASE;
                end
                S_PHASE: begin
                    r_phase <= r_phase + r_step;
                    r_state <= S_DUTY_A;
                end
                S_DUTY_A: begin
                    r_state <= S_DUTY_B;
                end
                S_DUTY_B: begin
                    r_duty_a <= w_prod[15:8] ^ 8'h80;
                    r_state  <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_duty_a <= r_duty_a;
                        r_out_duty_b <= w_prod[15:8] ^ 8'h80;
                        r_out_speed  <= r_speed;
                        r_out_halted <= (r_speed == '0);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_duty_a       = r_out_duty_a;
    assign o_duty_b       = r_out_duty_b;
    assign o_actual_speed = r_out_speed;
    assign o_halted       = r_out_halted;

    // An accepted item keeps the input side stalled on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after an item was accepted");

    // The halted flag agrees with the reported speed.
    a_halted_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_halted == (o_actual_speed == '0)))
        else $error("halted flag disagrees with actual speed");

    // A result appears only when the sequencer finishes an item.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result appeared outside the finish step");

endmodule

### dv/stepper_microstep_generator_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Stepper microstep generator testbench
// Drives target speed items into the generator and checks every coil result
// (both duties, the ramped speed and the halted flag) against an in-bench
// model of the ramp, amplitude map, phase accumulator and sine table. The
// run starts with a short directed table, then walks several register
// settings with random ramp sequences under random stalls on both sides.
// ---------------------------------------------------------------------------
module stepper_microstep_generator_unit_tb;
    import smg_pkg::*;

    // Register index that decodes to no register.
    localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

    // First quarter of the sine wave, amplitude 127, peak included.
    localparam int SINE_QTR [0:64] = '{
        0, 3, 6, 9, 12, 16, 19, 22, 25, 28, 31, 34, 37, 40, 43, 46,
        49, 51, 54, 57, 60, 63, 65, 68, 71, 73, 76, 78, 81, 83, 85, 88,
        90, 92, 94, 96, 98, 100, 102, 104, 106, 107, 109, 111, 112, 113, 115, 116,
        117, 118, 120, 121, 122, 122, 123, 124, 125, 125, 126, 126, 126, 127, 127, 127,
        127
    };

    typedef struct packed {
        logic [7:0]  duty_a;
        logic [7:0]  duty_b;
        logic [13:0] speed;
        logic        halted;
    } t_coil_result;

    typedef struct packed {
        logic [13:0]  target;
        logic         tick;
        logic         typed;
        t_coil_result result;
    } t_drive_row;

    // Directed items. Rows with the typed flag carry their result by hand.
    localparam int DIR_N = 24;
    localparam t_drive_row DIR_ROWS [0:DIR_N-1] = '{
        '{14'h1FFF, 1'b0, 1'b1, '{8'd128, 8'd128, 14'd0,  1'b1}},
        '{14'h0000, 1'b1, 1'b1, '{8'd128, 8'd172, 14'd0,  1'b1}},
        '{14'h1FFF, 1'b1, 1'b1, '{8'd128, 8'd172, 14'd80, 1'b0}},
        '{14'h2000, 1'b0, 1'b0, '0},
        '{14'h2000, 1'b1, 1'b0, '0},
        '{14'h2000, 1'b1, 1'b0, '0},
        '{14'h2000, 1'b1, 1'b0, '0},
        '{14'h3FFF, 1'b1, 1'b0, '0},
        '{14'h3FFF, 1'b1, 1'b0, '0},
        '{14'h3FFF, 1'b1, 1'b0, '0},
        '{14'h0001, 1'b1, 1'b0, '0},
        '{14'h0000, 1'b1, 1'b0, '0},
        '{14'h1FFF, 1'b1, 1'b0, '0},
        '{14'h1FFF, 1'b1, 1'b0, '0},
        '{14'h1FFF, 1'b1, 1'b0, '0},
        '{14'h1FFF, 1'b1, 1'b0, '0},
        '{14'h1FFF, 1'b1, 1'b0, '0},
        '{14'h1FFF, 1'b1, 1'b0, '0},
        '{14'h1FFF, 1'b1, 1'b0, '0},
        '{14'h1FFF, 1'b1, 1'b0, '0},
        '{14'h1FFF, 1'b1, 1'b0, '0},
        '{14'h1FFF, 1'b1, 1'b0, '0},
        '{14'h1FFF, 1'b0, 1'b0, '0},
        '{14'h2000, 1'b0, 1'b0, '0}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]         i_cfg_idx = '0;
    logic [CFG_DW-1:0]         i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [SPEED_W-1:0] i_target_speed = '0;
    logic                      i_ramp_tick = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [7:0]                o_duty_a;
    logic [7:0]                o_duty_b;
    logic signed [SPEED_W-1:0] o_actual_speed;
    logic                      o_halted;

    // Model registers, loaded with the reset defaults.
    logic [12:0] cfg_limit      = 13'd4320;
    logic [8:0]  cfg_accel      = 9'd80;
    logic [7:0]  cfg_amp_min    = 8'd90;
    logic [7:0]  cfg_amp_max    = 8'd255;
    logic [12:0] cfg_knee_speed = 13'd960;
    logic [15:0] cfg_slope      = 16'd352;
    logic [11:0] cfg_gain       = 12'd447;

    // Model drive state.
    logic [15:0] drv_phase = '0;
    int          drv_speed = 0;
    int          drv_step  = 0;
    int          drv_amp   = 0;

    t_coil_result pending_coil_q [$];
    int           mismatches = 0;

    // Stall shaping, set from the stimulus process.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    stepper_microstep_generator_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_target_speed (i_target_speed),
        .i_ramp_tick    (i_ramp_tick),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_duty_a       (o_duty_a),
        .o_duty_b       (o_duty_b),
        .o_actual_speed (o_actual_speed),
        .o_halted       (o_halted)
    );

    always #5 i_clk = ~i_clk;

    // Signed sine value for an 8-bit table index, built by quarter symmetry.
    function automatic int sine_at(logic [7:0] idx);
        int v;
        if (idx[6] == 1'b0) begin
            v = SINE_QTR[int'(idx[5:0])];
        end else begin
            v = SINE_QTR[64 - int'(idx[5:0])];
        end
        return idx[7] ? -v : v;
    endfunction

    // Duty is 128 plus the floored product of sine and amplitude over 256.
    function automatic logic [7:0] coil_duty(int tab, int amp);
        int p;
        p = tab * amp + 32768;
        return 8'(p >> 8);
    endfunction

    // Advances the drive model by one PWM period and returns its coil result.
    function automatic t_coil_result advance_drive(logic signed [13:0] target, logic tick);
        int           tgt;
        int           lim;
        int           mag;
        int           d;
        longint       a;
        longint       m;
        logic [7:0]   idx;
        t_coil_result r;
        if (tick) begin
            lim = int'(cfg_limit);
            tgt = int'(target);
            if (tgt > lim) begin
                tgt = lim;
            end else if (tgt < -lim) begin
                tgt = -lim;
            end
            // Step toward the clamped target without overshooting it.
            if (drv_speed < tgt) begin
                drv_speed = drv_speed + int'(cfg_accel);
                if (drv_speed > tgt) drv_speed = tgt;
            end else if (drv_speed > tgt) begin
                drv_speed = drv_speed - int'(cfg_accel);
                if (drv_speed < tgt) drv_speed = tgt;
            end
            mag = (drv_speed < 0) ? -drv_speed : drv_speed;
            // Amplitude: lower clamp first, then the linear map capped at the top.
            d = mag - int'(cfg_knee_speed);
            if (d <= 0) begin
                drv_amp = int'(cfg_amp_min);
            end else begin
                a = longint'(cfg_amp_min) + ((longint'(d) * longint'(cfg_slope)) >> 12);
                drv_amp = (a > longint'(cfg_amp_max)) ? int'(cfg_amp_max) : int'(a);
            end
            m = (longint'(mag) * longint'(cfg_gain)) >> 12;
            if (m > 32767) m = 32767;
            drv_step = (drv_speed < 0) ? -int'(m) : int'(m);
        end
        drv_phase = drv_phase + 16'(drv_step);
        idx = drv_phase[15:8];
        r.duty_a = coil_duty(sine_at(idx), drv_amp);
        r.duty_b = coil_duty(sine_at(idx + 8'd64), drv_amp);
        r.speed  = 14'(drv_speed);
        r.halted = (drv_speed == 0);
        return r;
    endfunction

    // Random target: anywhere, in or around the limit, zero, extremes, near zero.
    function automatic logic signed [13:0] pick_target();
        int lim;
        int v;
        lim = int'(cfg_limit);
        case ($urandom_range(5))
            0: v = int'($urandom_range(16383)) - 8192;
            1: begin
                v = lim + int'($urandom_range(40)) - 20;
                if ($urandom_range(1) == 0) v = -v;
            end
            2: v = 0;
            3: v = int'($urandom_range(2 * lim)) - lim;
            4: begin
                if ($urandom_range(1) == 0) v = 8191;
                else v = -8192;
            end
            default: begin
                v = int'($urandom_range(3 * int'(cfg_accel)));
                if ($urandom_range(1) == 0) v = -v;
            end
        endcase
        if (v > 8191) v = 8191;
        if (v < -8192) v = -8192;
        return 14'(v);
    endfunction

    // Fills the bits above a register's field with noise when asked to.
    function automatic logic [15:0] reg_word(int v, int w, bit widen);
        logic [15:0] r;
        r = 16'(v);
        if (widen && w < 16) r = r | (16'($urandom) << w);
        return r;
    endfunction

    // Offers one item, waits for it to be taken, and records its result.
    task automatic send_item(logic signed [13:0] tgt, logic tick,
                             bit typed = 1'b0, t_coil_result hand = '0);
        t_coil_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_target_speed <= tgt;
        i_ramp_tick    <= tick;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = advance_drive(tgt, tick);
        pending_coil_q.push_back(typed ? hand : predicted);
    endtask

    // One register write; the model takes the field's low bits.
    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_SPEED_LIMIT: cfg_limit      = data[12:0];
            REG_ACCEL_STEP:  cfg_accel      = data[8:0];
            REG_AMP_MIN:     cfg_amp_min    = data[7:0];
            REG_AMP_MAX:     cfg_amp_max    = data[7:0];
            REG_KNEE_SPEED:  cfg_knee_speed = data[12:0];
            REG_AMP_SLOPE:   cfg_slope      = data[15:0];
            REG_RATE_GAIN:   cfg_gain       = data[11:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(int lim, int acc, int amin, int amax, int knee,
                                 int slope, int gain, bit widen);
        if (widen) write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_SPEED_LIMIT, reg_word(lim, 13, widen));
        write_reg(REG_ACCEL_STEP,  reg_word(acc, 9, widen));
        write_reg(REG_AMP_MIN,     reg_word(amin, 8, widen));
        write_reg(REG_AMP_MAX,     reg_word(amax, 8, widen));
        write_reg(REG_KNEE_SPEED,  reg_word(knee, 13, widen));
        write_reg(REG_AMP_SLOPE,   reg_word(slope, 16, widen));
        write_reg(REG_RATE_GAIN,   reg_word(gain, 12, widen));
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_random_settings(bit widen);
        load_settings($urandom_range(16, 8000), $urandom_range(16, 320),
                      $urandom_range(255), $urandom_range(255), $urandom_range(8000),
                      $urandom_range(65535), $urandom_range(4095), widen);
    endtask

    // Stops offering and waits until every result is back and the block is idle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_coil_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Mostly held targets with random ramp ticks, some short runs of noisy items.
    task automatic run_random(int n_items);
        int               sent;
        int               len;
        int               k;
        int               tick_pct;
        logic signed [13:0] tgt;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 8) begin
                tgt      = pick_target();
                len      = $urandom_range(4, 60);
                tick_pct = $urandom_range(50, 100);
                for (k = 0; k < len && sent < n_items; k++) begin
                    send_item(tgt, $urandom_range(99) < tick_pct);
                    sent++;
                end
            end else begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len && sent < n_items; k++) begin
                    send_item(14'($urandom), 1'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is asked for.
    always @(posedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen   <= hold_asks;
            hold_left   <= 300;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_coil_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_coil_q.size() == 0) begin
                $error("result item with no expectation pending");
                mismatches++;
            end else begin
                e = pending_coil_q.pop_front();
                if (o_duty_a !== e.duty_a) begin
                    $error("duty_a: expected %0d, got %0d", e.duty_a, o_duty_a);
                    mismatches++;
                end
                if (o_duty_b !== e.duty_b) begin
                    $error("duty_b: expected %0d, got %0d", e.duty_b, o_duty_b);
                    mismatches++;
                end
                if (o_actual_speed !== e.speed) begin
                    $error("actual_speed: expected %0d, got %0d",
                           $signed(e.speed), o_actual_speed);
                    mismatches++;
                end
                if (o_halted !== e.halted) begin
                    $error("halted: expected %0d, got %0d", e.halted, o_halted);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        int i;
        send_idle_pct <= 17;
        recv_idle_pct <= 77;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under the reset defaults.
        for (i = 0; i < DIR_N; i++) begin
            send_item($signed(DIR_ROWS[i].target), DIR_ROWS[i].tick,
                      DIR_ROWS[i].typed, DIR_ROWS[i].result);
        end
        drain();

        // Upper ends of limit, step, slope, gain; amplitude minimum and knee zero.
        load_settings(8000, 320, 0, 255, 0, 65535, 4095, 1'b0);
        run_random(140);
        drain();

        // Lower ends of limit, step, slope, gain; high knee; min amplitude over max.
        load_settings(16, 16, 255, 0, 8000, 0, 0, 1'b0);
        run_random(130);
        drain();

        // Receiver mostly ready, sender mostly idle; junk in unused register bits.
        send_idle_pct <= 77;
        recv_idle_pct <= 17;
        load_random_settings(1'b1);
        run_random(140);
        drain();

        load_settings(3000, 100, 200, 50, 100, 4000, 2000, 1'b0);
        run_random(140);
        drain();

        // No idling; the receiver holds off long enough to back up the input.
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        load_random_settings(1'b0);
        hold_asks <= hold_asks + 1;
        run_random(140);
        drain();

        load_settings(4320, 80, 90, 255, 960, 352, 447, 1'b0);
        run_random(140);
        drain();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_coil_q.size() == 0) begin
            $display("[stepper_microstep_generator_unit] OK");
        end else begin
            $display("[stepper_microstep_generator_unit] ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("[stepper_microstep_generator_unit] ERROR");
        $finish;
    end

endmodule
